// ===== sv/supt_pkg.sv =====
// sorted unique port table: shared types, constants and the command/status
// structs between controller and datapath. no dependencies.

package supt_pkg;

    localparam int unsigned TABLE_DEPTH = 64;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CMP_W       = (CNT_W > 6) ? CNT_W : 6;
    localparam int unsigned KEY_W       = 24;

    localparam int unsigned IN_W  = 32;
    localparam int unsigned OUT_W = 40;

    localparam logic [1:0]  OP_INSERT   = 2'd0;
    localparam logic [1:0]  OP_CLEAR    = 2'd1;
    localparam int unsigned OP_READ_BIT = 1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_CLEARED  = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_J,
        RD_RIDX
    } t_rd_sel;

    typedef enum logic {
        WR_SHIFT,
        WR_KEY
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    idx_inc;
        logic    slot_load;
        logic    j_load;
        logic    j_dec;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    st_load;
        t_status st_code;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic idx_eq_count;
        logic rdata_eq;
        logic rdata_gt;
        logic count_full;
        logic ridx_lt_count;
        logic j_eq_slot;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/supt_dp.sv =====
// sorted unique port table datapath: pair memory, index counters, compare
// and the output register. depends on supt_pkg.

module supt_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_s_tdata,
    input  logic                i_m_tready,
    input  supt_pkg::t_cmd      i_cmd,
    output supt_pkg::t_stat     o_stat,
    output logic                o_m_tvalid,
    output logic [39:0]         o_m_tdata
);

    logic [supt_pkg::KEY_W-1:0] r_mem [supt_pkg::TABLE_DEPTH];

    logic [supt_pkg::KEY_W-1:0] r_key;
    logic [5:0]                 r_ridx;
    logic [supt_pkg::KEY_W-1:0] r_rdata;
    logic [supt_pkg::CNT_W-1:0] r_count;
    logic [supt_pkg::CNT_W-1:0] r_idx;
    logic [supt_pkg::CNT_W-1:0] r_slot;
    logic [supt_pkg::CNT_W-1:0] r_j;
    supt_pkg::t_status          r_status;
    logic                       r_out_valid;
    logic [39:0]                r_out_data;

    logic [supt_pkg::IDX_W-1:0] rd_addr;
    logic [supt_pkg::IDX_W-1:0] wr_addr;
    logic [supt_pkg::KEY_W-1:0] wr_data;
    logic [supt_pkg::CNT_W-1:0] j_prev;
    logic [supt_pkg::KEY_W-1:0] out_key;
    logic [5:0]                 out_pos;
    logic [39:0]                n_out_data;

    assign j_prev = r_j - supt_pkg::CNT_W'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            supt_pkg::RD_IDX:  rd_addr = r_idx[supt_pkg::IDX_W-1:0];
            supt_pkg::RD_J:    rd_addr = j_prev[supt_pkg::IDX_W-1:0];
            supt_pkg::RD_RIDX: rd_addr = supt_pkg::IDX_W'(r_ridx);
            default:           rd_addr = r_idx[supt_pkg::IDX_W-1:0];
        endcase
        case (i_cmd.wr_sel)
            supt_pkg::WR_SHIFT: begin
                wr_addr = r_j[supt_pkg::IDX_W-1:0];
                wr_data = r_rdata;
            end
            supt_pkg::WR_KEY: begin
                wr_addr = r_slot[supt_pkg::IDX_W-1:0];
                wr_data = r_key;
            end
            default: begin
                wr_addr = r_j[supt_pkg::IDX_W-1:0];
                wr_data = r_rdata;
            end
        endcase
    end

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= {i_s_tdata[25:18], i_s_tdata[17:2]};
            r_ridx <= i_s_tdata[31:26];
        end
        if (i_cmd.slot_load) begin
            r_slot <= r_idx;
        end
        if (i_cmd.j_load) begin
            r_j <= r_count;
        end else if (i_cmd.j_dec) begin
            r_j <= j_prev;
        end
        if (i_cmd.st_load) begin
            r_status <= i_cmd.st_code;
        end
        if (i_cmd.out_load) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + supt_pkg::CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + supt_pkg::CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        case (r_status)
            supt_pkg::ST_INSERTED,
            supt_pkg::ST_PRESENT: begin
                out_key = r_key;
                out_pos = 6'(r_slot);
            end
            supt_pkg::ST_FULL: begin
                out_key = r_key;
                out_pos = '0;
            end
            supt_pkg::ST_READ_OK: begin
                out_key = r_rdata;
                out_pos = r_ridx;
            end
            supt_pkg::ST_EMPTY: begin
                out_key = '0;
                out_pos = r_ridx;
            end
            default: begin
                out_key = '0;
                out_pos = '0;
            end
        endcase
        n_out_data = {out_pos, out_key[23:16], out_key[15:0], 7'(r_count), r_status};
    end

    assign o_stat.idx_eq_count  = (r_idx == r_count);
    assign o_stat.rdata_eq      = (r_rdata == r_key);
    assign o_stat.rdata_gt      = (r_rdata > r_key);
    assign o_stat.count_full    = (r_count == supt_pkg::CNT_W'(supt_pkg::TABLE_DEPTH));
    assign o_stat.ridx_lt_count = (supt_pkg::CMP_W'(r_ridx) < supt_pkg::CMP_W'(r_count));
    assign o_stat.j_eq_slot     = (r_j == r_slot);
    assign o_stat.out_free      = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== sv/supt_ctrl.sv =====
// sorted unique port table controller: sequences search, shift, insert,
// clear and read over the datapath. depends on supt_pkg.

module supt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic [1:0]          i_opcode,
    input  supt_pkg::t_stat     i_stat,
    output logic                o_s_tready,
    output supt_pkg::t_cmd      o_cmd
);

    supt_pkg::t_state r_state;
    supt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= supt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            supt_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (i_opcode[supt_pkg::OP_READ_BIT]) begin
                        n_state = supt_pkg::S_READ;
                    end else if (i_opcode == supt_pkg::OP_CLEAR) begin
                        o_cmd.cnt_clr = 1'b1;
                        o_cmd.st_load = 1'b1;
                        o_cmd.st_code = supt_pkg::ST_CLEARED;
                        n_state       = supt_pkg::S_DONE;
                    end else begin
                        n_state = supt_pkg::S_SRCH_RD;
                    end
                end
            end
            supt_pkg::S_SRCH_RD: begin
                if (i_stat.idx_eq_count) begin
                    // no entry at or above the key: append at the end
                    o_cmd.slot_load = 1'b1;
                    o_cmd.j_load    = 1'b1;
                    if (i_stat.count_full) begin
                        o_cmd.st_load = 1'b1;
                        o_cmd.st_code = supt_pkg::ST_FULL;
                        n_state       = supt_pkg::S_DONE;
                    end else begin
                        n_state = supt_pkg::S_SHIFT_RD;
                    end
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = supt_pkg::RD_IDX;
                    n_state      = supt_pkg::S_SRCH_CMP;
                end
            end
            supt_pkg::S_SRCH_CMP: begin
                if (i_stat.rdata_eq) begin
                    o_cmd.slot_load = 1'b1;
                    o_cmd.st_load   = 1'b1;
                    o_cmd.st_code   = supt_pkg::ST_PRESENT;
                    n_state         = supt_pkg::S_DONE;
                end else if (i_stat.rdata_gt) begin
                    o_cmd.slot_load = 1'b1;
                    o_cmd.j_load    = 1'b1;
                    if (i_stat.count_full) begin
                        o_cmd.st_load = 1'b1;
                        o_cmd.st_code = supt_pkg::ST_FULL;
                        n_state       = supt_pkg::S_DONE;
                    end else begin
                        n_state = supt_pkg::S_SHIFT_RD;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = supt_pkg::S_SRCH_RD;
                end
            end
            supt_pkg::S_SHIFT_RD: begin
                if (i_stat.j_eq_slot) begin
                    n_state = supt_pkg::S_PUT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = supt_pkg::RD_J;
                    n_state      = supt_pkg::S_SHIFT_WR;
                end
            end
            supt_pkg::S_SHIFT_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = supt_pkg::WR_SHIFT;
                o_cmd.j_dec  = 1'b1;
                n_state      = supt_pkg::S_SHIFT_RD;
            end
            supt_pkg::S_PUT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = supt_pkg::WR_KEY;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.st_load = 1'b1;
                o_cmd.st_code = supt_pkg::ST_INSERTED;
                n_state       = supt_pkg::S_DONE;
            end
            supt_pkg::S_READ: begin
                if (i_stat.ridx_lt_count) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = supt_pkg::RD_RIDX;
                    n_state      = supt_pkg::S_READ_WAIT;
                end else begin
                    o_cmd.st_load = 1'b1;
                    o_cmd.st_code = supt_pkg::ST_EMPTY;
                    n_state       = supt_pkg::S_DONE;
                end
            end
            supt_pkg::S_READ_WAIT: begin
                o_cmd.st_load = 1'b1;
                o_cmd.st_code = supt_pkg::ST_READ_OK;
                n_state       = supt_pkg::S_DONE;
            end
            supt_pkg::S_DONE: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = supt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = supt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sorted_unique_port_table.sv =====
// sorted unique port table, top level: joins controller and datapath.
// depends on supt_pkg, supt_ctrl and supt_dp.
//
// keeps up to TABLE_DEPTH unique (protocol, port) pairs in ascending order,
// protocol as the major key. one request transaction on the slave side gives
// exactly one result transaction on the master side.
// request: insert a pair, clear the table, or read the entry at an index.
// result: status, entry count after the operation, pair and its position.
// one request is handled at a time; ready is high only while idle.
// steps: a clear goes straight to the result; a read in range fetches the entry,
//   then gives the result; an insert searches up from index 0, then moves each
//   entry at or above the slot up one slot, from the end down, then writes the
//   pair into the slot.
// the table memory has one write port and a registered read: each search step
// reads an entry and then compares it; each move reads an entry, then writes it.
// a finished result sits in the output register; the next request is taken
// while it waits, but that request's result waits until the register frees.
// reset empties the table at once; memory contents are not cleared.

module sorted_unique_port_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // opcode[1:0], port_number[17:2], protocol_number[25:18], read_index[31:26]
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[2:0], entry_count[9:3], entry_port[25:10], entry_protocol[33:26],
    // position[39:34]
    output logic [39:0] o_m_tdata
);

    supt_pkg::t_cmd  cmd;
    supt_pkg::t_stat stat;

    supt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_opcode   (i_s_tdata[1:0]),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    supt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in progress");

    // no table write while a new request is being taken
    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_en |-> !o_s_tready)
        else $error("table written while idle");

    // a result is only loaded into a free output register
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result overwrote a pending transaction");

    // never grow a full table
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cnt_inc |-> !stat.count_full)
        else $error("entry count incremented on a full table");

endmodule

// ===== bench/sorted_unique_port_table_test.sv =====
// testbench for sorted_unique_port_table: a queue-fed stream driver, a result monitor
// and a table predictor compared field by field. depends on supt_pkg and the rtl top.
`timescale 1ns / 100ps

module sorted_unique_port_table_test;

    localparam logic [1:0] OP_READ    = 2'b10;
    localparam logic [1:0] OP_READ_HI = 2'b11;  // bit 0 ignored, still a read

    localparam int unsigned RANDOM_ITEMS   = 1500;
    localparam int unsigned DIRECTED_ITEMS = 20;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned TAIL_CYCLES    = 4 * supt_pkg::TABLE_DEPTH + 64;
    localparam int unsigned PHASE_ITEMS    = 200;

    typedef struct packed {
        logic [5:0]  ridx;
        logic [7:0]  proto;
        logic [15:0] port;
        logic [1:0]  opcode;
    } t_table_request;

    typedef struct packed {
        logic [5:0]        position;
        logic [7:0]        proto;
        logic [15:0]       port;
        logic [6:0]        count;
        supt_pkg::t_status status;
    } t_table_result;

    typedef struct {
        t_table_request req;
        bit             drain_first;  // hold off until every result is back
    } t_queued_request;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_tvalid = 1'b0;
    logic        req_tready;
    logic [31:0] req_tdata = '0;
    logic        res_tvalid;
    logic        res_tready = 1'b0;
    logic [39:0] res_tdata;
    logic        req_taken = 1'b0;

    t_queued_request pending_requests[$];
    t_table_result   expected_results[$];

    logic [23:0] table_keys [supt_pkg::TABLE_DEPTH];
    int unsigned table_count = 0;

    int unsigned total_requests = 0;
    int unsigned accepted_requests = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;

    sorted_unique_port_table dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (req_tvalid),
        .o_s_tready (req_tready),
        .i_s_tdata  (req_tdata),
        .o_m_tvalid (res_tvalid),
        .i_m_tready (res_tready),
        .o_m_tdata  (res_tdata)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic t_table_result apply_table_op(t_table_request rq);
        t_table_result res;
        logic [23:0]   key;
        int unsigned   slot;
        res = '0;
        key = {rq.proto, rq.port};
        if (rq.opcode[supt_pkg::OP_READ_BIT]) begin
            res.position = rq.ridx;
            if (rq.ridx < table_count) begin
                res.status = supt_pkg::ST_READ_OK;
                {res.proto, res.port} = table_keys[rq.ridx];
            end else begin
                res.status = supt_pkg::ST_EMPTY;
            end
        end else if (rq.opcode == supt_pkg::OP_CLEAR) begin
            table_count = 0;
            res.status = supt_pkg::ST_CLEARED;
        end else begin
            slot = table_count;
            for (int i = 0; i < table_count; i++) begin
                if (slot == table_count && table_keys[i] >= key)
                    slot = i;
            end
            {res.proto, res.port} = key;
            if (slot < table_count && table_keys[slot] == key) begin
                res.status = supt_pkg::ST_PRESENT;
                res.position = 6'(slot);
            end else if (table_count >= supt_pkg::TABLE_DEPTH) begin
                res.status = supt_pkg::ST_FULL;
            end else begin
                for (int i = table_count; i > slot; i--)
                    table_keys[i] = table_keys[i - 1];
                table_keys[slot] = key;
                table_count++;
                res.status = supt_pkg::ST_INSERTED;
                res.position = 6'(slot);
            end
        end
        res.count = 7'(table_count);
        return res;
    endfunction

    function automatic bit field_differs(string field, logic [23:0] want, logic [23:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_request(logic [1:0] op, logic [15:0] port, logic [7:0] proto,
                                        logic [5:0] ridx, bit drain);
        t_queued_request item;
        item.req.opcode = op;
        item.req.port = port;
        item.req.proto = proto;
        item.req.ridx = ridx;
        item.drain_first = drain;
        pending_requests.push_back(item);
    endfunction

    // the usual transport protocols and the key extremes, with random values mixed in
    function automatic logic [7:0] pick_proto();
        case ($urandom_range(5))
            0: return 8'd6;
            1: return 8'd17;
            2: return 8'd0;
            3: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] read_op();
        return $urandom_range(1) ? OP_READ : OP_READ_HI;
    endfunction

    function automatic int unsigned idle_phase();
        return (accepted_requests / PHASE_ITEMS) % 4;
    endfunction

    // driver: requests and receiver ready change on the falling edge
    always @(negedge clk) begin
        t_queued_request item;
        bit              sender_idle;
        bit              receiver_stall;
        case (idle_phase())
            1: begin
                sender_idle = $urandom_range(99) < 77;
                receiver_stall = 1'b0;
            end
            2: begin
                sender_idle = 1'b0;
                receiver_stall = $urandom_range(99) < 77;
            end
            3: begin
                sender_idle = $urandom_range(99) < 34;
                receiver_stall = $urandom_range(99) < 34;
            end
            default: begin
                sender_idle = 1'b0;
                receiver_stall = 1'b0;
            end
        endcase
        if (!rst_n) begin
            req_tvalid <= 1'b0;
            res_tready <= 1'b0;
        end else begin
            if (!req_tvalid || req_taken) begin
                if (pending_requests.size() > 0 && !sender_idle &&
                    !(pending_requests[0].drain_first && expected_results.size() > 0)) begin
                    item = pending_requests.pop_front();
                    req_tdata <= item.req;
                    req_tvalid <= 1'b1;
                end else begin
                    req_tvalid <= 1'b0;
                end
            end
            res_tready <= !receiver_stall;
        end
    end

    // monitor: both handshakes sampled on the rising edge
    always @(posedge clk) begin
        t_table_result want;
        t_table_result got;
        bit            bad;
        if (!rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_tvalid && req_tready;
            if (req_tvalid && req_tready) begin
                expected_results.push_back(apply_table_op(t_table_request'(req_tdata)));
                accepted_requests++;
            end
            if (res_tvalid && res_tready) begin
                got = t_table_result'(res_tdata);
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %h",
                             $time, res_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    bad = field_differs("status", 24'(want.status), 24'(got.status));
                    bad |= field_differs("entry_count", 24'(want.count), 24'(got.count));
                    bad |= field_differs("entry_port", 24'(want.port), 24'(got.port));
                    bad |= field_differs("entry_protocol", 24'(want.proto), 24'(got.proto));
                    bad |= field_differs("position", 24'(want.position), 24'(got.position));
                    if (bad)
                        mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_tvalid && req_tready) || (res_tvalid && res_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int unsigned n;

        // directed: key extremes, ordering, duplicates, reads in and out of range
        add_request(read_op(), 16'hffff, 8'hff, 6'd0, 1'b0);
        add_request(supt_pkg::OP_INSERT, 16'd80, 8'd6, 6'd63, 1'b0);
        add_request(supt_pkg::OP_INSERT, 16'd53, 8'd17, 6'd0, 1'b0);
        add_request(supt_pkg::OP_INSERT, 16'd22, 8'd6, 6'd0, 1'b0);
        add_request(supt_pkg::OP_INSERT, 16'd80, 8'd6, 6'd0, 1'b0);
        add_request(supt_pkg::OP_INSERT, 16'd0, 8'd0, 6'd0, 1'b0);
        add_request(supt_pkg::OP_INSERT, 16'hffff, 8'hff, 6'd0, 1'b0);
        add_request(supt_pkg::OP_INSERT, 16'd0, 8'hff, 6'd0, 1'b0);
        add_request(supt_pkg::OP_INSERT, 16'hffff, 8'd0, 6'd0, 1'b0);
        add_request(supt_pkg::OP_INSERT, 16'd0, 8'd0, 6'd0, 1'b0);
        add_request(OP_READ, 16'd0, 8'd0, 6'd0, 1'b0);
        add_request(OP_READ, 16'hffff, 8'hff, 6'd6, 1'b0);
        add_request(OP_READ, 16'd0, 8'd0, 6'd7, 1'b0);
        add_request(OP_READ, 16'd0, 8'd0, 6'd63, 1'b0);
        add_request(OP_READ_HI, 16'd0, 8'd0, 6'd1, 1'b0);
        add_request(OP_READ_HI, 16'd0, 8'd0, 6'd63, 1'b0);
        add_request(supt_pkg::OP_CLEAR, 16'hffff, 8'hff, 6'd63, 1'b1);
        add_request(OP_READ, 16'd0, 8'd0, 6'd0, 1'b0);
        add_request(supt_pkg::OP_INSERT, 16'hffff, 8'hff, 6'd63, 1'b0);
        add_request(supt_pkg::OP_CLEAR, 16'd0, 8'd0, 6'd0, 1'b0);

        while (pending_requests.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            case ($urandom_range(4))
                0, 1: begin
                    // fill past capacity so that drops and the top slot get exercised
                    add_request(supt_pkg::OP_CLEAR, 16'($urandom), 8'($urandom),
                                6'($urandom), $urandom_range(4) == 0);
                    n = supt_pkg::TABLE_DEPTH + $urandom_range(8, 1);
                    for (int k = 0; k < n; k++) begin
                        add_request(supt_pkg::OP_INSERT, 16'($urandom), pick_proto(),
                                    6'($urandom), 1'b0);
                        if ($urandom_range(9) == 0)
                            add_request(supt_pkg::OP_INSERT, pending_requests[$].req.port,
                                        pending_requests[$].req.proto, 6'($urandom), 1'b0);
                        if ($urandom_range(7) == 0)
                            add_request(read_op(), 16'($urandom), 8'($urandom),
                                        6'($urandom), 1'b0);
                    end
                    for (int k = 0; k < 4; k++)
                        add_request(read_op(), 16'($urandom), 8'($urandom),
                                    6'(supt_pkg::TABLE_DEPTH - 1 - $urandom_range(2)), 1'b0);
                end
                2: begin
                    // small key pool: many duplicates and close neighbours
                    if ($urandom_range(1))
                        add_request(supt_pkg::OP_CLEAR, 16'($urandom), 8'($urandom),
                                    6'($urandom), $urandom_range(4) == 0);
                    n = $urandom_range(40, 10);
                    for (int k = 0; k < n; k++) begin
                        if ($urandom_range(3) == 0)
                            add_request(read_op(), 16'($urandom), 8'($urandom),
                                        6'($urandom_range(15)), 1'b0);
                        else
                            add_request(supt_pkg::OP_INSERT,
                                        16'($urandom_range(7)) << $urandom_range(15),
                                        $urandom_range(1) ? 8'd6 : 8'd17, 6'($urandom), 1'b0);
                    end
                end
                default: begin
                    // noise: any opcode, any field contents
                    n = $urandom_range(30, 10);
                    for (int k = 0; k < n; k++)
                        add_request(2'($urandom), 16'($urandom), 8'($urandom), 6'($urandom),
                                    k == 0 && $urandom_range(4) == 0);
                end
            endcase
        end
        total_requests = pending_requests.size();

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_requests < total_requests || expected_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/supt_pkg.sv
sv/supt_dp.sv
sv/supt_ctrl.sv
sv/sorted_unique_port_table.sv
bench/sorted_unique_port_table_test.sv
